/* hdl/acr_pkg.sv */
package acr_pkg;

	// field widths
	localparam int AGE_W    = 24;
	localparam int POS_W    = 32;
	localparam int CH_W     = 16;
	localparam int STOP_W   = 3 * CH_W;
	localparam int CNT_W    = 3;
	localparam int CFG_W    = STOP_W;
	localparam int IDX_W    = 3;

	// ramp geometry
	localparam int MAX_STOPS = 6;
	localparam int MAX_SLOTS = MAX_STOPS - 1;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int SCALED_W  = AGE_W + CNT_W;

	// fraction and divider shape
	localparam int FRAC_W         = 16;
	localparam int WEIGHT_W       = FRAC_W + 1;
	localparam int DIV_BITS_STAGE = 2;
	localparam int DIV_STAGES     = FRAC_W / DIV_BITS_STAGE;
	localparam int PROD_W         = 2 * CH_W;

	localparam logic [WEIGHT_W-1:0] ONE_Q16   = WEIGHT_W'(1) << FRAC_W;
	localparam logic [PROD_W:0]     ROUND_Q16 = (PROD_W + 1)'(1) << (FRAC_W - 1);

	// register reset values
	localparam logic [AGE_W-1:0]  HIGH_AGE_RST   = AGE_W'(256);
	localparam logic [CNT_W-1:0]  STOP_COUNT_RST = CNT_W'(2);
	localparam logic [STOP_W-1:0] STOP_ZERO_RST  = '0;
	localparam logic [STOP_W-1:0] STOP_ONES_RST  = '1;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_HIGH_AGE   = 3'd0,
		REG_STOP_COUNT = 3'd1,
		REG_STOP0      = 3'd2,
		REG_STOP1      = 3'd3,
		REG_STOP2      = 3'd4,
		REG_STOP3      = 3'd5,
		REG_STOP4      = 3'd6,
		REG_STOP5      = 3'd7
	} reg_idx_t;

	// one particle
	typedef struct packed {
		logic                    hidden;
		logic [AGE_W-1:0]        age;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} in_item_t;

	// one colored vertex
	typedef struct packed {
		logic signed [POS_W-1:0] out_x;
		logic signed [POS_W-1:0] out_y;
		logic signed [POS_W-1:0] out_z;
		logic [CH_W-1:0]         red;
		logic [CH_W-1:0]         green;
		logic [CH_W-1:0]         blue;
	} out_item_t;

endpackage

/* hdl/age_color_ramp.sv */
// channel   | direction | handshake                      | item
// particle  | in        | particle_valid, particle_stall | particle (hidden, age, position)
// vertex    | out       | vertex_valid, vertex_stall     | vertex (position, red, green, blue)
// config    | in        | cfg_we                         | cfg_idx, cfg_data
//
// one particle per cycle while vertex_stall does not hold the pipeline; a visible particle
// passes 14 register stages: scale, slot select, remainder, eight radix-4
// fraction divider stages, stop select, blend multiply, round
// hidden particles are dropped at entry and leave a bubble
// arst_n clears all valid bits and loads the register reset values
// vertex_stall on a valid vertex freezes the whole pipeline; particle_stall follows it directly

module age_color_ramp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     particle_valid,
	output logic                     particle_stall,
	input  acr_pkg::in_item_t        particle,
	output logic                     vertex_valid,
	input  logic                     vertex_stall,
	output acr_pkg::out_item_t       vertex,
	input  logic                     cfg_we,
	input  logic [acr_pkg::IDX_W-1:0] cfg_idx,
	input  logic [acr_pkg::CFG_W-1:0] cfg_data
);
	import acr_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic              v;
		pos_t              pos;
		logic [SLOT_W-1:0] idx;
		logic              sat;
		logic [AGE_W-1:0]  rem;
		logic [FRAC_W-1:0] quo;
	} div_t;

	// configuration registers
	logic [AGE_W-1:0]  high_age_q;
	logic [CNT_W-1:0]  stop_count_q;
	logic [STOP_W-1:0] stop0_q, stop1_q, stop2_q, stop3_q, stop4_q, stop5_q;

	// multiples of the effective high age, k * H for slot k
	logic [SCALED_W-1:0] hmul_q [0:MAX_SLOTS-1];

	logic               en;
	logic [AGE_W-1:0]   heff;
	logic [CNT_W-1:0]   slots;

	// pipeline registers
	logic                v_s1, v_s2, v_s3, v_s12, v_s13, vertex_valid_s14;
	pos_t                pos_s1, pos_s2, pos_s3, pos_s12, pos_s13;
	logic [SCALED_W-1:0] scaled_s1, scaled_s2;
	logic [SLOT_W-1:0]   idx_s2, idx_s3;
	logic [AGE_W-1:0]    num_s3;
	logic                sat_s3;
	div_t                div_s [0:DIV_STAGES-1];
	div_t                div_in [0:DIV_STAGES-1];
	div_t                div_nx [0:DIV_STAGES-1];
	logic [STOP_W-1:0]   lo_s12, hi_s12;
	logic [WEIGHT_W-1:0] t_s12, omt_s12;
	logic [PROD_W-1:0]   plo_s13 [0:2];
	logic [PROD_W-1:0]   phi_s13 [0:2];
	out_item_t           vertex_s14;

	// comb helpers
	logic [SLOT_W-1:0]   idx_nx;
	logic [SCALED_W-1:0] num_nx;
	logic [STOP_W-1:0]   lo_nx, hi_nx;
	logic [WEIGHT_W-1:0] t_nx;
	div_t                div_last;

	// the whole pipeline moves unless a finished item is held
	assign en             = !(vertex_valid_s14 && vertex_stall);
	assign particle_stall = !en;
	assign vertex_valid   = vertex_valid_s14;
	assign vertex         = vertex_s14;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_age_q   <= HIGH_AGE_RST;
			stop_count_q <= STOP_COUNT_RST;
			stop0_q      <= STOP_ZERO_RST;
			stop1_q      <= STOP_ONES_RST;
			stop2_q      <= STOP_ZERO_RST;
			stop3_q      <= STOP_ZERO_RST;
			stop4_q      <= STOP_ZERO_RST;
			stop5_q      <= STOP_ZERO_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HIGH_AGE:   high_age_q   <= cfg_data[AGE_W-1:0];
				REG_STOP_COUNT: stop_count_q <= cfg_data[CNT_W-1:0];
				REG_STOP0:      stop0_q      <= cfg_data[STOP_W-1:0];
				REG_STOP1:      stop1_q      <= cfg_data[STOP_W-1:0];
				REG_STOP2:      stop2_q      <= cfg_data[STOP_W-1:0];
				REG_STOP3:      stop3_q      <= cfg_data[STOP_W-1:0];
				REG_STOP4:      stop4_q      <= cfg_data[STOP_W-1:0];
				REG_STOP5:      stop5_q      <= cfg_data[STOP_W-1:0];
				default: ;
			endcase
		end
	end

	// zero high age acts as one; stop count clamped to 2..MAX_STOPS
	always_comb begin
		heff = (high_age_q == '0) ? AGE_W'(1) : high_age_q;
		if (stop_count_q < CNT_W'(2))
			slots = CNT_W'(1);
		else if (stop_count_q > CNT_W'(MAX_STOPS))
			slots = CNT_W'(MAX_SLOTS);
		else
			slots = stop_count_q - CNT_W'(1);
	end

	// slot boundaries, refreshed every cycle from the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_SLOTS; k++)
				hmul_q[k] <= SCALED_W'(HIGH_AGE_RST) * SCALED_W'(k);
		end else begin
			for (int k = 0; k < MAX_SLOTS; k++)
				hmul_q[k] <= SCALED_W'(heff) * SCALED_W'(k);
		end
	end

	// s1: scale age by slot count, drop hidden particles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= particle_valid && !particle.hidden;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1    <= '{x: particle.pos_x, y: particle.pos_y, z: particle.pos_z};
			scaled_s1 <= SCALED_W'(particle.age) * SCALED_W'(slots);
		end
	end

	// s2: slot index is the count of boundaries passed, clamped to the last slot
	always_comb begin
		idx_nx = '0;
		for (int k = 1; k < MAX_SLOTS; k++) begin
			if (scaled_s1 >= hmul_q[k] && CNT_W'(k) < slots)
				idx_nx = idx_nx + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2    <= pos_s1;
			scaled_s2 <= scaled_s1;
			idx_s2    <= idx_nx;
		end
	end

	// s3: remainder within the slot; a full slot or more saturates the fraction
	assign num_nx = scaled_s2 - hmul_q[idx_s2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s3 <= pos_s2;
			idx_s3 <= idx_s2;
			sat_s3 <= num_nx >= SCALED_W'(heff);
			num_s3 <= num_nx[AGE_W-1:0];
		end
	end

	// s4..s11: restoring divider, remainder * 2^16 / H, two quotient bits a stage
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		if (g == 0) begin : g_first
			always_comb begin
				div_in[g].v   = v_s3;
				div_in[g].pos = pos_s3;
				div_in[g].idx = idx_s3;
				div_in[g].sat = sat_s3;
				div_in[g].rem = sat_s3 ? '0 : num_s3;
				div_in[g].quo = '0;
			end
		end else begin : g_next
			assign div_in[g] = div_s[g-1];
		end

		always_comb begin
			logic [AGE_W:0] shl;
			div_nx[g] = div_in[g];
			for (int b = 0; b < DIV_BITS_STAGE; b++) begin
				shl = {div_nx[g].rem, 1'b0};
				if (shl >= {1'b0, heff}) begin
					div_nx[g].rem = AGE_W'(shl - {1'b0, heff});
					div_nx[g].quo = {div_nx[g].quo[FRAC_W-2:0], 1'b1};
				end else begin
					div_nx[g].rem = shl[AGE_W-1:0];
					div_nx[g].quo = {div_nx[g].quo[FRAC_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[g] <= '0;
			end else if (en) begin
				div_s[g] <= div_nx[g];
			end
		end
	end

	assign div_last = div_s[DIV_STAGES-1];

	// s12: pick the two neighboring stops and the blend weights
	always_comb begin
		case (div_last.idx)
			SLOT_W'(0): begin
				lo_nx = stop0_q;
				hi_nx = stop1_q;
			end
			SLOT_W'(1): begin
				lo_nx = stop1_q;
				hi_nx = stop2_q;
			end
			SLOT_W'(2): begin
				lo_nx = stop2_q;
				hi_nx = stop3_q;
			end
			SLOT_W'(3): begin
				lo_nx = stop3_q;
				hi_nx = stop4_q;
			end
			SLOT_W'(4): begin
				lo_nx = stop4_q;
				hi_nx = stop5_q;
			end
			default: begin
				lo_nx = stop0_q;
				hi_nx = stop1_q;
			end
		endcase
		t_nx = div_last.sat ? ONE_Q16 : {1'b0, div_last.quo};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= div_last.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s12 <= div_last.pos;
			lo_s12  <= lo_nx;
			hi_s12  <= hi_nx;
			t_s12   <= t_nx;
			omt_s12 <= ONE_Q16 - t_nx;
		end
	end

	// s13: weighted products per channel, each below 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s13 <= pos_s12;
			for (int c = 0; c < 3; c++) begin
				plo_s13[c] <= PROD_W'(lo_s12[STOP_W-1-CH_W*c -: CH_W]) * PROD_W'(omt_s12);
				phi_s13[c] <= PROD_W'(hi_s12[STOP_W-1-CH_W*c -: CH_W]) * PROD_W'(t_s12);
			end
		end
	end

	// s14: round half up and drop the fraction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_valid_s14 <= 1'b0;
		end else if (en) begin
			vertex_valid_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		logic [PROD_W:0] sum [0:2];
		if (en) begin
			for (int c = 0; c < 3; c++)
				sum[c] = (PROD_W + 1)'(plo_s13[c]) + (PROD_W + 1)'(phi_s13[c]) + ROUND_Q16;
			vertex_s14.out_x <= pos_s13.x;
			vertex_s14.out_y <= pos_s13.y;
			vertex_s14.out_z <= pos_s13.z;
			vertex_s14.red   <= sum[0][PROD_W-1:FRAC_W];
			vertex_s14.green <= sum[1][PROD_W-1:FRAC_W];
			vertex_s14.blue  <= sum[2][PROD_W-1:FRAC_W];
		end
	end

endmodule

/* hdl/acr_checker.sv */
module acr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               particle_stall,
	input logic               vertex_valid,
	input logic               vertex_stall,
	input acr_pkg::out_item_t vertex
);
	import acr_pkg::*;

	// a held item stays and keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_stall |=> vertex_valid && $stable(vertex))
		else $error("held vertex item dropped or changed");

	// input stalls exactly when a finished item is held at the output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		particle_stall == (vertex_valid && vertex_stall))
		else $error("particle stall does not follow the output hold");

	// nothing leaves during reset
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !vertex_valid)
		else $error("vertex item shown during reset");

endmodule

bind age_color_ramp acr_checker u_acr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.particle_stall (particle_stall),
	.vertex_valid   (vertex_valid),
	.vertex_stall   (vertex_stall),
	.vertex         (vertex)
);

/* bench/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import acr_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int MAX_GAP       = 17;
	localparam int PIPE_DEPTH    = 14;
	localparam int SETTLE_CYCLES = 3 * PIPE_DEPTH;
	localparam int LONG_HOLD     = 300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 40;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 120;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam longint unsigned UNITY    = 64'd1 << FRAC_W;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b1;
	logic               particle_valid = 1'b0;
	logic               particle_stall;
	in_item_t           particle       = '0;
	logic               vertex_valid;
	logic               vertex_stall   = 1'b0;
	out_item_t          vertex;
	logic               cfg_we         = 1'b0;
	logic [IDX_W-1:0]   cfg_idx        = '0;
	logic [CFG_W-1:0]   cfg_data       = '0;

	// ramp registers as the block should hold them
	logic [AGE_W-1:0]   ramp_high_age   = HIGH_AGE_RST;
	logic [CNT_W-1:0]   ramp_stop_count = STOP_COUNT_RST;
	logic [STOP_W-1:0]  ramp_stops [MAX_STOPS];

	out_item_t          vertex_q [$];

	int  error_count        = 0;
	int  cycle_count        = 0;
	int  sent_count         = 0;
	int  hidden_count       = 0;
	int  vertex_count       = 0;
	int  ramp_settings      = 0;
	int  input_stall_cycles = 0;
	int  sink_hold          = 0;
	bit  feed_steady        = 1'b0;
	bit  sink_steady        = 1'b0;

	age_color_ramp dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.particle_valid (particle_valid),
		.particle_stall (particle_stall),
		.particle       (particle),
		.vertex_valid   (vertex_valid),
		.vertex_stall   (vertex_stall),
		.vertex         (vertex),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// register reset values of the stops
	initial begin
		foreach (ramp_stops[i]) ramp_stops[i] = STOP_ZERO_RST;
		ramp_stops[1] = STOP_ONES_RST;
	end

	task automatic report_mismatch(string msg);
		if (error_count < MAX_REPORTS)
			$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// stops in use minus one, with the count clamped to 2..MAX_STOPS
	function automatic longint unsigned ramp_slots();
		longint unsigned n;
		n = ramp_stop_count;
		if (n < 2)
			n = 2;
		if (n > MAX_STOPS)
			n = MAX_STOPS;
		return n - 1;
	endfunction

	// high age with zero treated as one
	function automatic longint unsigned ramp_span();
		return (ramp_high_age == '0) ? 64'd1 : 64'(ramp_high_age);
	endfunction

	// linear mix of two channels, rounded half up
	function automatic logic [CH_W-1:0] blend_channel(longint unsigned lo, longint unsigned hi,
			longint unsigned frac);
		return CH_W'((lo * (UNITY - frac) + hi * frac + (UNITY >> 1)) >> FRAC_W);
	endfunction

	// colored vertex for one visible particle under the current ramp
	function automatic out_item_t predict_vertex(in_item_t p);
		out_item_t v;
		longint unsigned slots, span, scaled, slot, rem, frac;
		int lo, hi;
		slots  = ramp_slots();
		span   = ramp_span();
		scaled = 64'(p.age) * slots;
		slot   = scaled / span;
		if (slot > slots - 1)
			slot = slots - 1;
		rem  = scaled - slot * span;
		frac = (rem << FRAC_W) / span;
		if (frac > UNITY)
			frac = UNITY;
		lo = int'(slot);
		hi = lo + 1;
		v.out_x = p.pos_x;
		v.out_y = p.pos_y;
		v.out_z = p.pos_z;
		v.red   = blend_channel(ramp_stops[lo][3*CH_W-1 -: CH_W],
			ramp_stops[hi][3*CH_W-1 -: CH_W], frac);
		v.green = blend_channel(ramp_stops[lo][2*CH_W-1 -: CH_W],
			ramp_stops[hi][2*CH_W-1 -: CH_W], frac);
		v.blue  = blend_channel(ramp_stops[lo][CH_W-1:0], ramp_stops[hi][CH_W-1:0], frac);
		return v;
	endfunction

	function automatic in_item_t particle_at(logic hide, logic [AGE_W-1:0] age);
		in_item_t p;
		p.hidden = hide;
		p.age    = age;
		p.pos_x  = $urandom;
		p.pos_y  = $urandom;
		p.pos_z  = $urandom;
		return p;
	endfunction

	function automatic logic [STOP_W-1:0] random_stop();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		return STOP_W'({$urandom, $urandom});
	endfunction

	function automatic logic [POS_W-1:0] random_pos();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return POS_MIN;
		else if (pick == 1)
			return POS_MAX;
		else if (pick == 2)
			return '0;
		return $urandom;
	endfunction

	// ages mostly inside the ramp, some on slot borders, some anywhere
	function automatic in_item_t random_particle();
		in_item_t p;
		longint unsigned span, slots, age, top;
		int pick;
		span  = ramp_span();
		slots = ramp_slots();
		pick  = $urandom_range(0, 9);
		if (pick < 6) begin
			top = span + span / 4;
			if (top > AGE_MAX)
				top = AGE_MAX;
			age = $urandom_range(0, int'(top));
		end else if (pick < 8) begin
			age = (64'($urandom_range(0, int'(slots))) * span) / slots;
			age = age + $urandom_range(0, 2);
			age = (age == 0) ? 0 : age - 1;
			if (age > AGE_MAX)
				age = AGE_MAX;
		end else if (pick == 8) begin
			age = $urandom_range(0, 1) ? 64'(AGE_MAX) : 64'd0;
		end else begin
			age = $urandom & 32'(AGE_MAX);
		end
		p = particle_at($urandom_range(0, 7) == 0, AGE_W'(age));
		p.pos_x = random_pos();
		p.pos_y = random_pos();
		p.pos_z = random_pos();
		return p;
	endfunction

	// offer one particle after a random gap and book its vertex when taken
	task automatic send_particle(in_item_t p);
		int gap;
		gap = feed_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			particle_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		particle_valid <= 1'b1;
		particle       <= p;
		@(posedge clk);
		while (particle_stall !== 1'b0) @(posedge clk);
		sent_count++;
		if (p.hidden)
			hidden_count++;
		else
			vertex_q.push_back(predict_vertex(p));
		if ($urandom_range(0, 63) == 0)
			feed_steady = ~feed_steady;
	endtask

	// stop feeding, let every vertex out, then let the pipeline settle
	task automatic drain_pipeline();
		particle_valid <= 1'b0;
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// load the whole ramp; unused upper data bits carry noise
	task automatic apply_ramp();
		logic [CFG_W-1:0] noise;
		noise = CFG_W'({$urandom, $urandom});
		write_reg(REG_HIGH_AGE, {noise[CFG_W-1:AGE_W], ramp_high_age});
		write_reg(REG_STOP_COUNT, {noise[CFG_W-1:CNT_W], ramp_stop_count});
		write_reg(REG_STOP0, ramp_stops[0]);
		write_reg(REG_STOP1, ramp_stops[1]);
		write_reg(REG_STOP2, ramp_stops[2]);
		write_reg(REG_STOP3, ramp_stops[3]);
		write_reg(REG_STOP4, ramp_stops[4]);
		write_reg(REG_STOP5, ramp_stops[5]);
		cfg_we <= 1'b0;
		ramp_settings++;
	endtask

	// black to white over 256 as left by reset
	task automatic test_reset_ramp();
		in_item_t p;
		p = particle_at(1'b0, '0);
		p.pos_x = POS_MAX;
		p.pos_y = POS_MIN;
		p.pos_z = '0;
		send_particle(p);
		send_particle(particle_at(1'b0, AGE_W'(1)));
		send_particle(particle_at(1'b0, AGE_W'(128)));
		send_particle(particle_at(1'b1, AGE_W'(128)));
		send_particle(particle_at(1'b0, AGE_W'(255)));
		send_particle(particle_at(1'b0, AGE_W'(256)));
		send_particle(particle_at(1'b0, AGE_W'(257)));
		p = particle_at(1'b0, AGE_MAX);
		p.pos_x = POS_MIN;
		p.pos_y = POS_MAX;
		p.pos_z = '1;
		send_particle(p);
	endtask

	// clamped stop counts, zero and full high age, exact slot borders
	task automatic test_ramp_corners();
		in_item_t p;
		drain_pipeline();
		ramp_high_age   = '0;
		ramp_stop_count = CNT_W'(0);
		foreach (ramp_stops[i]) ramp_stops[i] = random_stop();
		apply_ramp();
		send_particle(particle_at(1'b0, '0));
		send_particle(particle_at(1'b0, AGE_W'(1)));
		send_particle(particle_at(1'b0, AGE_MAX));

		drain_pipeline();
		ramp_high_age   = AGE_MAX;
		ramp_stop_count = '1;
		foreach (ramp_stops[i]) ramp_stops[i] = (i % 2) ? STOP_ONES_RST : STOP_ZERO_RST;
		apply_ramp();
		send_particle(particle_at(1'b0, '0));
		send_particle(particle_at(1'b0, AGE_MAX >> 1));
		send_particle(particle_at(1'b0, AGE_MAX - 1));
		send_particle(particle_at(1'b0, AGE_MAX));

		drain_pipeline();
		ramp_high_age   = AGE_W'(1);
		ramp_stop_count = CNT_W'(1);
		foreach (ramp_stops[i]) ramp_stops[i] = random_stop();
		apply_ramp();
		send_particle(particle_at(1'b0, '0));
		send_particle(particle_at(1'b0, AGE_W'(1)));
		p = particle_at(1'b1, AGE_W'(1));
		p.pos_x = '1;
		p.pos_y = '1;
		p.pos_z = '1;
		send_particle(p);

		// six stops, slots of 100
		drain_pipeline();
		ramp_high_age   = AGE_W'(500);
		ramp_stop_count = CNT_W'(MAX_STOPS);
		foreach (ramp_stops[i]) ramp_stops[i] = random_stop();
		apply_ramp();
		send_particle(particle_at(1'b0, AGE_W'(99)));
		send_particle(particle_at(1'b0, AGE_W'(100)));
		send_particle(particle_at(1'b0, AGE_W'(250)));
		send_particle(particle_at(1'b0, AGE_W'(499)));
		send_particle(particle_at(1'b0, AGE_W'(500)));
		send_particle(particle_at(1'b0, AGE_W'(600)));
	endtask

	// output held off long while particles keep coming back to back
	task automatic test_backpressure();
		drain_pipeline();
		feed_steady = 1'b1;
		sink_hold   = LONG_HOLD;
		repeat (60) send_particle(random_particle());
		feed_steady = 1'b0;
		drain_pipeline();
	endtask

	// random ramps, the first two at the extremes
	task automatic test_random_ramps();
		int pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_pipeline();
			pick = $urandom_range(0, 3);
			if (phase == 0)
				ramp_high_age = AGE_MAX;
			else if (phase == 1)
				ramp_high_age = AGE_W'(1);
			else if (pick == 0)
				ramp_high_age = AGE_W'($urandom_range(1, 255));
			else if (pick == 1)
				ramp_high_age = AGE_W'($urandom_range(1, 4096));
			else if (pick == 2)
				ramp_high_age = AGE_W'(1) << $urandom_range(0, AGE_W - 1);
			else
				ramp_high_age = AGE_W'($urandom_range(1, int'(AGE_MAX)));
			if (phase == 0)
				ramp_stop_count = CNT_W'(MAX_STOPS);
			else if (phase == 1)
				ramp_stop_count = CNT_W'(2);
			else if ($urandom_range(0, 7) == 0)
				ramp_stop_count = CNT_W'($urandom);
			else
				ramp_stop_count = CNT_W'($urandom_range(2, MAX_STOPS));
			foreach (ramp_stops[i]) ramp_stops[i] = random_stop();
			apply_ramp();
			repeat (PHASE_ITEMS) send_particle(random_particle());
		end
	endtask

	// vertex side: random stalls per item, plus the long hold on request
	initial begin : vertex_sink
		int hold;
		@(posedge arst_n);
		forever begin
			if (sink_hold > 0) begin
				hold      = sink_hold;
				sink_hold = 0;
			end else begin
				hold = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold > 0) begin
				vertex_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			vertex_stall <= 1'b0;
			@(posedge clk);
			while (vertex_valid !== 1'b1) @(posedge clk);
			if ($urandom_range(0, 63) == 0)
				sink_steady = ~sink_steady;
		end
	end

	task automatic check_field(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("vertex %0d %s got %h want %h",
				vertex_count, name, got, want));
	endtask

	// compare each vertex taken with the oldest one booked
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n === 1'b1 && vertex_valid === 1'b1 && vertex_stall === 1'b0) begin
			if (vertex_q.size() == 0) begin
				report_mismatch($sformatf("vertex %0d with none expected", vertex_count));
			end else begin
				want = vertex_q.pop_front();
				check_field("out_x", vertex.out_x, want.out_x);
				check_field("out_y", vertex.out_y, want.out_y);
				check_field("out_z", vertex.out_z, want.out_z);
				check_field("red", vertex.red, want.red);
				check_field("green", vertex.green, want.green);
				check_field("blue", vertex.blue, want.blue);
			end
			vertex_count++;
		end
	end

	// cycle count and input hold-off count
	always @(posedge clk) begin
		cycle_count++;
		if (particle_valid === 1'b1 && particle_stall === 1'b1)
			input_stall_cycles++;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("tb: no progress after %0d cycles, %0d vertices still expected",
			cycle_count, vertex_q.size());
		$display("tb: failure");
		$finish;
	end

	initial begin : run
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_ramp();
		test_ramp_corners();
		test_backpressure();
		test_random_ramps();
		drain_pipeline();
		$display("tb: %0d particles (%0d hidden), %0d vertices checked, %0d ramp settings",
			sent_count, hidden_count, vertex_count, ramp_settings);
		$display("tb: input held off for %0d cycles, %0d mismatches",
			input_stall_cycles, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* age_color_ramp.f */
hdl/acr_pkg.sv
hdl/age_color_ramp.sv
hdl/acr_checker.sv
bench/tb.sv
